// ----- sv/dnsle_pkg.sv -----
// Shared constants and types of the DNS name label encoder.
// No dependencies; every other file but the label RAM refers to this package.
package dnsle_pkg;

  localparam int MAX_LABEL   = 62;
  localparam int STORE_DEPTH = 62;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_LABEL + 1);
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;

  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'd46;
  localparam logic [BYTE_W-1:0] TERM_BYTE = 8'd0;

  // One result word as handed from the sequencer to the output stage.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] byte_val;
    logic              last;
    logic [LEN_W-1:0]  enc_len;
    logic              ovf;
  } out_word_t;

endpackage

// ----- sv/dnsle_label_ram.sv -----
// Single-port-write, single-port-read label buffer with a registered read.
// Generic RAM; uses no package.
module dnsle_label_ram #(
  parameter int DEPTH  = 62,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued, so a stalled consumer keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/dnsle_out_stage.sv -----
// Output register of the encoder: holds one result word until it is taken.
// Depends on dnsle_pkg for the result word type.
module dnsle_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dnsle_pkg::out_word_t      push,
  output logic                      can_push,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dnsle_pkg::BYTE_W-1:0] out_byte,
  output logic                      out_last_of_run,
  output logic [dnsle_pkg::LEN_W-1:0]  out_encoded_length,
  output logic                      out_label_overflow
);

  logic                         valid_r;
  logic [dnsle_pkg::BYTE_W-1:0] byte_r;
  logic                         last_r;
  logic [dnsle_pkg::LEN_W-1:0]  len_r;
  logic                         ovf_r;

  assign can_push = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push.valid && can_push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && can_push) begin
      byte_r <= push.byte_val;
      last_r <= push.last;
      len_r  <= push.enc_len;
      ovf_r  <= push.ovf;
    end
  end

  assign out_valid          = valid_r;
  assign out_byte           = byte_r;
  assign out_last_of_run    = last_r;
  assign out_encoded_length = len_r;
  assign out_label_overflow = ovf_r;

endmodule

// ----- sv/dnsle_ctrl.sv -----
// Sequencer of the encoder: buffers label characters in the label RAM and
// replays them as length byte plus data. Depends on dnsle_pkg.
module dnsle_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [dnsle_pkg::BYTE_W-1:0]       in_char_code,
  output logic                               wr_en,
  output logic [dnsle_pkg::ADDR_W-1:0]       wr_addr,
  output logic [dnsle_pkg::BYTE_W-1:0]       wr_data,
  output logic                               rd_en,
  output logic [dnsle_pkg::ADDR_W-1:0]       rd_addr,
  input  logic [dnsle_pkg::BYTE_W-1:0]       rd_data,
  output dnsle_pkg::out_word_t               push,
  input  logic                               can_push
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH_LEN,
    ST_FLUSH_DATA,
    ST_TERM
  } state_t;

  localparam int CNT_W  = dnsle_pkg::CNT_W;
  localparam int ADDR_W = dnsle_pkg::ADDR_W;
  localparam int LEN_W  = dnsle_pkg::LEN_W;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [ADDR_W-1:0]            idx_r, idx_nxt;
  logic                         dot_r, dot_nxt;
  logic [LEN_W-1:0]             len_r, len_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         then_term_r, then_term_nxt;
  logic [dnsle_pkg::BYTE_W-1:0] char_r, char_nxt;

  logic                         apply_en;
  logic [dnsle_pkg::BYTE_W-1:0] apply_code;
  logic [CNT_W-1:0]             apply_cnt;
  logic                         flush_done;
  logic                         last_idx;
  logic [LEN_W:0]               len_inc;
  logic [LEN_W:0]               len_sum;
  logic [LEN_W-1:0]             len_sat;

  // Saturating length update: one more byte for the terminator, otherwise
  // the label's bytes plus its length byte.
  always_comb begin
    len_inc = (state_r == ST_TERM) ? (LEN_W+1)'(1) : (LEN_W+1)'(count_r) + (LEN_W+1)'(1);
    len_sum = {1'b0, len_r} + len_inc;
    len_sat = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
  end

  assign last_idx = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    dot_nxt       = dot_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    then_term_nxt = then_term_r;
    char_nxt      = char_r;
    in_ready      = 1'b0;
    push          = '0;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[ADDR_W-1:0];
    wr_data       = in_char_code;
    apply_en      = 1'b0;
    apply_code    = in_char_code;
    apply_cnt     = count_r;
    flush_done    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            // A pending dot is final here and is dropped.
            then_term_nxt = 1'b1;
            dot_nxt       = 1'b0;
            state_nxt     = (count_r != '0) ? ST_FLUSH_LEN : ST_TERM;
          end else if (dot_r) begin
            then_term_nxt = 1'b0;
            char_nxt      = in_char_code;
            dot_nxt       = 1'b0;
            state_nxt     = ST_FLUSH_LEN;
          end else begin
            apply_en = 1'b1;
          end
        end
      end
      ST_FLUSH_LEN: begin
        if (can_push) begin
          push.valid    = 1'b1;
          push.byte_val = dnsle_pkg::BYTE_W'(count_r);
          push.last     = (count_r == '0) && !then_term_r;
          push.ovf      = ovf_r;
          if (count_r == '0) begin
            flush_done = 1'b1;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            idx_nxt   = '0;
            state_nxt = ST_FLUSH_DATA;
          end
        end
      end
      ST_FLUSH_DATA: begin
        if (can_push) begin
          push.valid    = 1'b1;
          push.byte_val = rd_data;
          push.last     = last_idx && !then_term_r;
          push.ovf      = ovf_r;
          if (last_idx) begin
            flush_done = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + ADDR_W'(1);
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end
      ST_TERM: begin
        if (can_push) begin
          push.valid    = 1'b1;
          push.byte_val = dnsle_pkg::TERM_BYTE;
          push.last     = 1'b1;
          push.enc_len  = len_sat;
          push.ovf      = ovf_r;
          count_nxt     = '0;
          dot_nxt       = 1'b0;
          len_nxt       = '0;
          ovf_nxt       = 1'b0;
          then_term_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Closing a label: account for its bytes, then either finish the name
    // or take in the character that followed the dot.
    if (flush_done) begin
      len_nxt   = len_sat;
      count_nxt = '0;
      apply_cnt = '0;
      if (then_term_r) begin
        state_nxt = ST_TERM;
      end else begin
        apply_en   = 1'b1;
        apply_code = char_r;
        state_nxt  = ST_IDLE;
      end
    end

    // The RAM write never meets a read of the same entry: reads happen only
    // while flushing, and the write after a flush lands when no read issues.
    if (apply_en) begin
      if (apply_code == dnsle_pkg::DOT_CHAR) begin
        dot_nxt = 1'b1;
      end else if (apply_cnt < CNT_W'(dnsle_pkg::MAX_LABEL)) begin
        wr_en     = 1'b1;
        wr_addr   = apply_cnt[ADDR_W-1:0];
        wr_data   = apply_code;
        count_nxt = apply_cnt + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      dot_r       <= 1'b0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      then_term_r <= 1'b0;
      char_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      dot_r       <= dot_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      then_term_r <= then_term_nxt;
      char_r      <= char_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(dnsle_pkg::MAX_LABEL))
    else $error("label count beyond maximum label length");

  a_read_in_label: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CNT_W'(rd_addr) < count_r))
    else $error("label RAM read outside the buffered label");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> can_push)
    else $error("result pushed while the output stage is full");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TERM && can_push) |=> (count_r == '0 && len_r == '0 && !dot_r && !ovf_r))
    else $error("name state not cleared after the terminator");

  a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH_DATA) |-> (CNT_W'(idx_r) < count_r))
    else $error("flush index beyond the buffered label");

endmodule

// ----- sv/dns_name_label_encoder.sv -----
// Top level of the DNS name label encoder: label RAM, sequencer, output stage.
// Depends on dnsle_pkg, dnsle_label_ram, dnsle_ctrl and dnsle_out_stage.
//
// The block takes a host name one character word at a time (in_mode 0) and
// an end-of-name word (in_mode 1), and sends the uncompressed DNS wire form
// as a stream of byte words: for each label a length byte and the label's
// characters, then a zero terminator that carries the total encoded length
// (saturating at 65535) and the overflow flag. Characters past 62 in one
// label are dropped and flagged; a single final dot is dropped. A character
// that does not close a label is taken without leaving the idle state, and
// the next word is accepted in the following cycle. A word that closes a
// label of n bytes occupies the block while it sends the length byte, then
// one byte per cycle out of the single read port of the label RAM as long as
// the result side takes them; an end-of-name word then adds the terminator,
// and one that finds no buffered label goes straight to the terminator.
// Stalls on the result side hold this sequence where it stands. A finished
// result waits in the output register, so character words that make no
// output keep flowing while it is not yet taken.
module dns_name_label_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic [15:0] out_encoded_length,
  output logic        out_label_overflow
);

  logic                               wr_en;
  logic [dnsle_pkg::ADDR_W-1:0]       wr_addr;
  logic [dnsle_pkg::BYTE_W-1:0]       wr_data;
  logic                               rd_en;
  logic [dnsle_pkg::ADDR_W-1:0]       rd_addr;
  logic [dnsle_pkg::BYTE_W-1:0]       rd_data;
  dnsle_pkg::out_word_t               push;
  logic                               can_push;

  // Characters of the label being collected.
  dnsle_label_ram #(
    .DEPTH  (dnsle_pkg::STORE_DEPTH),
    .WIDTH  (dnsle_pkg::BYTE_W),
    .ADDR_W (dnsle_pkg::ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer that holds the name state and replays labels.
  dnsle_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_char_code (in_char_code),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .push         (push),
    .can_push     (can_push)
  );

  // Output register that decouples the result channel.
  dnsle_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .can_push           (can_push),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_last_of_run    (out_last_of_run),
    .out_encoded_length (out_encoded_length),
    .out_label_overflow (out_label_overflow)
  );

endmodule

// ----- tb/sv/dns_name_label_encoder_tb.sv -----
// Self-checking testbench for dns_name_label_encoder: a table of directed names
// followed by random names and a closing name of dots, checked against a local encoder.
// Depends on dnsle_pkg and on the RTL of the block; it needs nothing else.
module dns_name_label_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              MAX_LABEL = dnsle_pkg::MAX_LABEL;
  localparam logic [7:0]      DOT_CHAR  = dnsle_pkg::DOT_CHAR;
  localparam logic [7:0]      TERM_BYTE = dnsle_pkg::TERM_BYTE;

  // Meaning of in_mode.
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // The run is far shorter than this. The slowest legal run is a few hundred
  // words whose results may each wait out a receiver stall, plus one long hold-off.
  localparam int LIMIT_CYCLES = 200_000;
  // A label of up to 62 bytes may still have to leave the block; this drain covers it.
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_WORDS = 220;
  // A closing name made of this many dots gives a run of empty labels.
  localparam int DOT_RUN      = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 100;

  // One encoded output word as the block should present it.
  typedef struct packed {
    logic [7:0]  byte_val;
    logic        last;
    logic [15:0] enc_len;
    logic        ovf;
  } wire_word_t;

  // One row of the directed table. Where typed is set, the row's single
  // expected word is written out in the row instead of coming from the encoder.
  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
    bit         typed;
    logic [7:0] t_byte;
    logic [15:0] t_len;
    logic       t_ovf;
  } name_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = MODE_CHAR;
  logic [7:0]  in_char_code = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic [15:0] out_encoded_length;
  logic        out_label_overflow;

  // State of the local encoder. It mirrors what the block holds for the name
  // that is being encoded.
  logic [7:0]  label_bytes [MAX_LABEL];
  int          label_len;
  bit          dot_held;
  int          name_len;
  bit          name_ovf;

  wire_word_t  step_words [$];   // words caused by the word just accepted
  wire_word_t  wire_q [$];       // words still owed by the block, oldest first

  int          fail_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;      // no idling on either side
  bit          tx_idle_on = 1'b1;
  bit          hold_req = 1'b0;   // asks the receiver for one long hold-off

  // Directed names. Only the words whose result is obvious are typed in: the
  // empty name and a name made of a single dot, both of which give a lone zero
  // terminator with a length of 1.
  name_row_t name_rows [18] = '{
    // The empty name, straight after reset.
    '{MODE_END,  8'h00,    1'b1, TERM_BYTE, 16'd1, 1'b0},
    // A single dot is final and is dropped.
    '{MODE_CHAR, DOT_CHAR, 1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_END,  8'h00,    1'b1, TERM_BYTE, 16'd1, 1'b0},
    // A label holding the two extreme character codes, closed by a dot.
    '{MODE_CHAR, 8'h00,    1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_CHAR, 8'hFF,    1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_CHAR, DOT_CHAR, 1'b0, 8'h00, 16'd0, 1'b0},
    // A second dot closes the first label; the character after it closes an
    // empty label.
    '{MODE_CHAR, DOT_CHAR, 1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_CHAR, 8'h2D,    1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_CHAR, 8'h2F,    1'b0, 8'h00, 16'd0, 1'b0},
    // The character code of an end word is ignored.
    '{MODE_END,  8'hFF,    1'b0, 8'h00, 16'd0, 1'b0},
    // A leading dot gives an empty first label.
    '{MODE_CHAR, DOT_CHAR, 1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_CHAR, 8'h61,    1'b0, 8'h00, 16'd0, 1'b0},
    // A final dot after a nonempty label is dropped; a dot in an end word
    // means nothing.
    '{MODE_CHAR, DOT_CHAR, 1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_END,  DOT_CHAR, 1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_END,  8'hAA,    1'b1, TERM_BYTE, 16'd1, 1'b0},
    // Two dots: the first closes an empty label and the second is final.
    '{MODE_CHAR, DOT_CHAR, 1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_CHAR, DOT_CHAR, 1'b0, 8'h00, 16'd0, 1'b0},
    '{MODE_END,  8'h00,    1'b0, 8'h00, 16'd0, 1'b0}
  };

  dns_name_label_encoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_encoded_length(out_encoded_length),
    .out_label_overflow(out_label_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The watchdog ends a run that hangs.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic void clear_name();
    label_len = 0;
    dot_held  = 1'b0;
    name_len  = 0;
    name_ovf  = 1'b0;
  endfunction

  // The running length saturates at the width of the length field.
  function automatic void grow_name(input int n);
    name_len += n;
    if (name_len > 65535) name_len = 65535;
  endfunction

  function automatic void put_word(input logic [7:0] b, input logic [15:0] len);
    wire_word_t w;
    w.byte_val = b;
    w.last     = 1'b0;
    w.enc_len  = len;
    w.ovf      = name_ovf;
    step_words.push_back(w);
  endfunction

  // Sends the buffered label: its length byte, then its characters.
  function automatic void emit_label();
    put_word(8'(label_len), 16'd0);
    for (int i = 0; i < label_len; i++) put_word(label_bytes[i], 16'd0);
    grow_name(label_len + 1);
    label_len = 0;
  endfunction

  // Works out the words that one accepted input word causes and leaves them in
  // step_words, with last set on the final one.
  function automatic void encode_word(input logic m, input logic [7:0] c);
    wire_word_t w;
    step_words.delete();
    if (m == MODE_END) begin
      // A dot still held here is the final dot and is simply dropped.
      if (label_len > 0) emit_label();
      grow_name(1);
      put_word(TERM_BYTE, 16'(name_len));
      clear_name();
    end else begin
      if (dot_held) begin
        emit_label();
        dot_held = 1'b0;
      end
      if (c == DOT_CHAR) begin
        dot_held = 1'b1;
      end else if (label_len < MAX_LABEL) begin
        label_bytes[label_len] = c;
        label_len++;
      end else begin
        name_ovf = 1'b1;
      end
    end
    if (step_words.size() > 0) begin
      w = step_words[step_words.size() - 1];
      w.last = 1'b1;
      step_words[step_words.size() - 1] = w;
    end
  endfunction

  function automatic void queue_step();
    foreach (step_words[i]) wire_q.push_back(step_words[i]);
  endfunction

  function automatic void report(input string field, input int exp_v, input int act_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
  endfunction

  // Offers one word and returns at the clock edge that accepts it. Valid is
  // never lowered between back-to-back words, only before an idle burst.
  task automatic send_word(input logic m, input logic [7:0] c);
    if (!quiet && tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= m;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    encode_word(m, c);
  endtask

  task automatic send_and_check(input logic m, input logic [7:0] c);
    send_word(m, c);
    queue_step();
  endtask

  // One well-formed name with random content. Most labels are short; a forced
  // name carries a label of exactly the maximum length and one that overflows.
  task automatic send_name(input bit force_long, inout int words);
    int n_labels;
    int lab_len;
    logic [7:0] c;
    n_labels = force_long ? 2 : $urandom_range(0, 4);
    if ($urandom_range(0, 9) == 0) begin
      send_and_check(MODE_CHAR, DOT_CHAR);
      words++;
    end
    for (int l = 0; l < n_labels; l++) begin
      if (force_long)                        lab_len = (l == 0) ? MAX_LABEL : 70;
      else if ($urandom_range(0, 24) == 0)   lab_len = $urandom_range(60, 70);
      else                                   lab_len = $urandom_range(0, 10);
      for (int k = 0; k < lab_len; k++) begin
        c = 8'($urandom_range(0, 255));
        if (c == DOT_CHAR) c = 8'h2D;
        send_and_check(MODE_CHAR, c);
        words++;
      end
      // Dots between labels; an empty label then shows up as a double dot.
      if (l < n_labels - 1 || $urandom_range(0, 4) == 0) begin
        send_and_check(MODE_CHAR, DOT_CHAR);
        words++;
      end
    end
    send_and_check(MODE_END, 8'($urandom_range(0, 255)));
    words++;
  endtask

  // Receiver: takes words, compares them with the oldest expectation, and
  // decides out_ready for the next edge. Stalls come in bursts; once, on
  // request, it holds off long enough for the block to fill and stall its input.
  initial begin
    int stall_left;
    wire_word_t w;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (wire_q.size() == 0) begin
          report("unexpected out_byte", -1, int'(out_byte));
        end else begin
          w = wire_q.pop_front();
          if (out_byte !== w.byte_val)          report("out_byte", int'(w.byte_val),
                                                       int'(out_byte));
          if (out_last_of_run !== w.last)       report("out_last_of_run", int'(w.last),
                                                       int'(out_last_of_run));
          if (out_encoded_length !== w.enc_len) report("out_encoded_length",
                                                       int'(w.enc_len),
                                                       int'(out_encoded_length));
          if (out_label_overflow !== w.ovf)     report("out_label_overflow", int'(w.ovf),
                                                       int'(out_label_overflow));
        end
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, the directed table, random names with noise, and finally
  // one name made only of dots.
  initial begin
    int words;
    int name_cnt;
    logic m;
    logic [7:0] c;
    wire_word_t tw;
    words    = 0;
    name_cnt = 0;
    clear_name();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (name_rows[i]) begin
      send_word(name_rows[i].mode, name_rows[i].ch);
      if (name_rows[i].typed) begin
        tw.byte_val = name_rows[i].t_byte;
        tw.last     = 1'b1;
        tw.enc_len  = name_rows[i].t_len;
        tw.ovf      = name_rows[i].t_ovf;
        wire_q.push_back(tw);
      end else begin
        queue_step();
      end
    end

    // The first random name has the long labels, and it is sent without idling
    // while the receiver holds off, so the block backs up into its input.
    hold_req = 1'b1;
    while (words < RANDOM_WORDS) begin
      tx_idle_on = (name_cnt > 0) && ($urandom_range(0, 3) != 0);
      if (name_cnt > 0 && $urandom_range(0, 9) == 0) begin
        // Noise: stray words that may break a name anywhere.
        repeat ($urandom_range(1, 4)) begin
          m = ($urandom_range(0, 3) == 0) ? MODE_END : MODE_CHAR;
          c = $urandom_range(0, 1) ? DOT_CHAR : 8'($urandom_range(0, 255));
          send_and_check(m, c);
          words++;
        end
      end else begin
        send_name(name_cnt == 0, words);
        name_cnt++;
      end
    end

    // Last part, without idling: a name of nothing but dots. Each dot after the
    // first closes an empty label, and the final dot is dropped.
    quiet = 1'b1;
    repeat (DOT_RUN) send_and_check(MODE_CHAR, DOT_CHAR);
    send_and_check(MODE_END, 8'h00);
    in_valid <= 1'b0;

    while (wire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
